@@ hw/rtl/pip_pkg.sv @@
// shared types and constants for the point-in-polygon test core
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } walk_state_t;

  typedef struct packed {
    logic is_query;
    logic slot_ok;
  } cmd_ctrl_t;

endpackage

@@ hw/rtl/pip_ram.sv @@
// generic single write port, single read port ram with registered read
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/pip_front.sv @@
// front end: input transaction queue and command classification
module pip_front #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_VERTICES)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_mode,
  input  logic [IDX_W-1:0]             in_idx,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  output logic                         cmd_valid,
  input  logic                         cmd_pop,
  output pip_pkg::cmd_ctrl_t           cmd_ctrl,
  output logic [IDX_W-1:0]             cmd_idx,
  output logic signed [COORD_BITS-1:0] cmd_x,
  output logic signed [COORD_BITS-1:0] cmd_y
);

  pip_pkg::cmd_ctrl_t          ent_ctrl_r [2];
  logic [IDX_W-1:0]            ent_idx_r  [2];
  logic signed [COORD_BITS-1:0] ent_x_r   [2];
  logic signed [COORD_BITS-1:0] ent_y_r   [2];
  logic                        wr_ptr_r;
  logic                        rd_ptr_r;
  logic [1:0]                  cnt_r;
  logic                        do_push;
  logic                        do_pop;
  pip_pkg::cmd_ctrl_t          cls;

  // classify the incoming transaction
  always_comb begin
    cls.is_query = (in_mode == pip_pkg::MODE_QUERY);
    cls.slot_ok  = ({1'b0, in_idx} < (IDX_W + 1)'(MAX_VERTICES));
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_ctrl_r[wr_ptr_r] <= cls;
      ent_idx_r[wr_ptr_r]  <= in_idx;
      ent_x_r[wr_ptr_r]    <= in_x;
      ent_y_r[wr_ptr_r]    <= in_y;
    end
  end

  assign cmd_ctrl = ent_ctrl_r[rd_ptr_r];
  assign cmd_idx  = ent_idx_r[rd_ptr_r];
  assign cmd_x    = ent_x_r[rd_ptr_r];
  assign cmd_y    = ent_y_r[rd_ptr_r];

endmodule

@@ hw/rtl/pip_rq.sv @@
// result queue, two entries
module pip_rq (
  input  logic clk,
  input  logic rst_n,
  input  logic res_push,
  input  logic res_inside,
  output logic rq_full,
  output logic empty,
  input  logic pop,
  output logic out_inside
);

  logic       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign rq_full = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = res_push && !rq_full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= res_inside;
    end
  end

  assign out_inside = ent_r[rd_ptr_r];

endmodule

@@ hw/rtl/pip_back.sv @@
// back end: vertex store, edge walk sequencer and crossing pipeline
module pip_back #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_VERTICES),
  localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CNT_W-1:0]             cfg_count,
  input  logic                         cmd_valid,
  output logic                         cmd_pop,
  input  pip_pkg::cmd_ctrl_t           cmd_ctrl,
  input  logic [IDX_W-1:0]             cmd_idx,
  input  logic signed [COORD_BITS-1:0] cmd_x,
  input  logic signed [COORD_BITS-1:0] cmd_y,
  input  logic                         rq_full,
  output logic                         res_push,
  output logic                         res_inside
);

  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D;

  pip_pkg::walk_state_t state_r, state_nxt;

  logic [CNT_W-1:0]             vcount_r;
  logic [CNT_W-1:0]             cnt_m1;
  logic                         cnt_zero;
  logic signed [COORD_BITS-1:0] qx_r, qy_r;
  logic [IDX_W-1:0]             nm1_r;
  logic [IDX_W-1:0]             addr_r;
  logic                         first_r;
  logic                         inside_r;

  logic                         ram_we;
  logic                         rd_en;
  logic                         rd_last;
  logic                         q_start;
  logic                         zero_push;
  logic                         done_push;
  logic [2*COORD_BITS-1:0]      rdata;

  // read stage
  logic                         r_vld_r, r_first_r, r_last_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic signed [COORD_BITS-1:0] xi, yi;
  // difference stage
  logic                         e_vld_r, e_last_r, e_str_r, e_pos_r;
  logic signed [D-1:0]          a_r, dy_r, c_r, d_r;
  logic signed [D-1:0]          xi_e, yi_e, xj_e, yj_e, px_e, py_e, dy_w;
  // product stage
  logic                         m_vld_r, m_last_r, m_str_r, m_pos_r;
  logic signed [P-1:0]          p1_r, p2_r;
  logic                         left;
  logic                         tog;

  assign cnt_m1   = vcount_r - CNT_W'(1);
  assign cnt_zero = (vcount_r == '0);

  // count register, saturated to the store depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (cfg_we) begin
      if (cfg_count > CNT_W'(MAX_VERTICES)) begin
        vcount_r <= CNT_W'(MAX_VERTICES);
      end else begin
        vcount_r <= cfg_count;
      end
    end
  end

  assign rd_last = (state_r == pip_pkg::ST_WALK) && !first_r && (addr_r == nm1_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pip_pkg::ST_IDLE: begin
        if (cmd_valid && cmd_ctrl.is_query && !rq_full && !cnt_zero) begin
          state_nxt = pip_pkg::ST_WALK;
        end
      end
      pip_pkg::ST_WALK: begin
        if (rd_last) begin
          state_nxt = pip_pkg::ST_DRAIN;
        end
      end
      pip_pkg::ST_DRAIN: begin
        if (m_vld_r && m_last_r) begin
          state_nxt = pip_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pip_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    ram_we  = 1'b0;
    q_start = 1'b0;
    rd_en   = 1'b0;
    unique case (state_r)
      pip_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (!cmd_ctrl.is_query) begin
            cmd_pop = 1'b1;
            ram_we  = cmd_ctrl.slot_ok;
          end else if (!rq_full) begin
            cmd_pop = 1'b1;
            q_start = 1'b1;
          end
        end
      end
      pip_pkg::ST_WALK: begin
        rd_en = 1'b1;
      end
      pip_pkg::ST_DRAIN: begin
        rd_en = 1'b0;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pip_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // walk sequencer: vertex n-1 first, then 0 .. n-1
  always_ff @(posedge clk) begin
    if (q_start) begin
      qx_r    <= cmd_x;
      qy_r    <= cmd_y;
      nm1_r   <= cnt_m1[IDX_W-1:0];
      addr_r  <= cnt_m1[IDX_W-1:0];
      first_r <= 1'b1;
    end else if (rd_en) begin
      first_r <= 1'b0;
      if (first_r) begin
        addr_r <= '0;
      end else begin
        addr_r <= addr_r + IDX_W'(1);
      end
    end
  end

  pip_ram #(
    .WIDTH(2 * COORD_BITS),
    .DEPTH(MAX_VERTICES)
  ) u_vstore (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cmd_idx),
    .wdata({cmd_x, cmd_y}),
    .re   (rd_en),
    .raddr(addr_r),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else begin
      r_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    r_first_r <= first_r;
    r_last_r  <= rd_last;
  end

  assign xi = $signed(rdata[2*COORD_BITS-1:COORD_BITS]);
  assign yi = $signed(rdata[COORD_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (r_vld_r) begin
      prev_x_r <= xi;
      prev_y_r <= yi;
    end
  end

  assign xi_e = D'(xi);
  assign yi_e = D'(yi);
  assign xj_e = D'(prev_x_r);
  assign yj_e = D'(prev_y_r);
  assign px_e = D'(qx_r);
  assign py_e = D'(qy_r);
  assign dy_w = yj_e - yi_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= r_vld_r && !r_first_r;
    end
  end

  always_ff @(posedge clk) begin
    e_last_r <= r_last_r;
    e_str_r  <= (yi > qy_r) != (prev_y_r > qy_r);
    e_pos_r  <= dy_w > 0;
    a_r      <= px_e - xi_e;
    dy_r     <= dy_w;
    c_r      <= xj_e - xi_e;
    d_r      <= py_e - yi_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m_last_r <= e_last_r;
    m_str_r  <= e_str_r;
    m_pos_r  <= e_pos_r;
    p1_r     <= P'(a_r) * P'(dy_r);
    p2_r     <= P'(c_r) * P'(d_r);
  end

  // crossing compare, direction follows the sign of the edge height
  assign left      = m_pos_r ? (p1_r < p2_r) : (p2_r < p1_r);
  assign tog       = m_vld_r && m_str_r && left;
  assign done_push = m_vld_r && m_last_r;
  assign zero_push = q_start && cnt_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else if (q_start) begin
      inside_r <= 1'b0;
    end else if (tog) begin
      inside_r <= !inside_r;
    end
  end

  assign res_push   = zero_push || done_push;
  assign res_inside = done_push ? (inside_r ^ tog) : 1'b0;

  a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    done_push |-> state_r == pip_pkg::ST_DRAIN)
    else $error("walk result outside drain");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !rq_full)
    else $error("result pushed into full queue");

  a_last_travels: assert property (@(posedge clk) disable iff (!rst_n)
    (r_vld_r && r_last_r) |=> (e_vld_r && e_last_r))
    else $error("last edge lost in pipeline");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !ram_we && !cmd_pop)
    else $error("command taken during walk");

endmodule

@@ hw/rtl/point_in_polygon_test_core.sv @@
// top level of the even-odd point-in-polygon test core
//
//  channel  | ports                                            | transaction
//  input    | push, full, in_mode, in_vertex_index, in_coord_* | push && !full
//  result   | empty, pop, out_inside_res                       | pop && !empty
//  config   | cfg_we, cfg_vertex_count                         | cfg_we
//
//  a vertex write is taken by the back end only while it is idle; a query walks the vertex
//  store from vertex n-1, then 0 .. n-1, through the difference and product stages and the
//  crossing compare; a query with a count of zero pushes its result in the same cycle it is taken
//  a two-entry input queue and a two-entry result queue decouple both sides
//  a query starts only when the result queue has room; reset is synchronous, active low
module point_in_polygon_test_core #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_VERTICES),
  localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_mode,
  input  logic [IDX_W-1:0]             in_vertex_index,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  output logic                         empty,
  input  logic                         pop,
  output logic                         out_inside_res,
  input  logic                         cfg_we,
  input  logic [CNT_W-1:0]             cfg_vertex_count
);

  logic                         cmd_valid;
  logic                         cmd_pop;
  pip_pkg::cmd_ctrl_t           cmd_ctrl;
  logic [IDX_W-1:0]             cmd_idx;
  logic signed [COORD_BITS-1:0] cmd_x;
  logic signed [COORD_BITS-1:0] cmd_y;
  logic                         rq_full;
  logic                         res_push;
  logic                         res_inside;

  pip_front #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_mode  (in_mode),
    .in_idx   (in_vertex_index),
    .in_x     (in_coord_x),
    .in_y     (in_coord_y),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd_ctrl (cmd_ctrl),
    .cmd_idx  (cmd_idx),
    .cmd_x    (cmd_x),
    .cmd_y    (cmd_y)
  );

  pip_back #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_count (cfg_vertex_count),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_ctrl  (cmd_ctrl),
    .cmd_idx   (cmd_idx),
    .cmd_x     (cmd_x),
    .cmd_y     (cmd_y),
    .rq_full   (rq_full),
    .res_push  (res_push),
    .res_inside(res_inside)
  );

  pip_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_inside(res_inside),
    .rq_full   (rq_full),
    .empty     (empty),
    .pop       (pop),
    .out_inside(out_inside_res)
  );

endmodule

@@ dv/tb_top.sv @@
// testbench for the point-in-polygon test core: crossing-parity scoreboard, stimulus and checks

class inside_scoreboard;
  localparam int NV = pip_pkg::MAX_VERTICES_DEF;
  localparam int CW = pip_pkg::COORD_BITS_DEF;
  localparam int CNT_BITS = $clog2(NV + 1);
  localparam int PRINT_CAP = 60;

  logic signed [CW-1:0] vert_x [NV];
  logic signed [CW-1:0] vert_y [NV];
  logic [CNT_BITS-1:0] count;
  bit inside_due_q [$];
  int fail_count;
  int inside_seen;
  int outside_seen;

  function new();
    foreach (vert_x[k]) begin
      vert_x[k] = '0;
      vert_y[k] = '0;
    end
    count = '0;
    fail_count = 0;
    inside_seen = 0;
    outside_seen = 0;
  endfunction

  task report(string what);
    fail_count++;
    if (fail_count <= PRINT_CAP) $display("MISMATCH %0d: %s", fail_count, what);
  endtask

  function void set_count(logic [CNT_BITS-1:0] value);
    count = value;
  endfunction

  // even-odd crossing parity, division replaced by a sign-aware cross-multiplied compare
  function bit crossing_parity(logic signed [CW-1:0] qx, logic signed [CW-1:0] qy);
    int n;
    int j;
    bit odd;
    longint px, py, xi, yi, xj, yj, dy, lhs, rhs;
    n = (count > NV) ? NV : count;
    px = qx;
    py = qy;
    odd = 1'b0;
    for (int i = 0; i < n; i++) begin
      j = (i == 0) ? n - 1 : i - 1;
      xi = vert_x[i];
      yi = vert_y[i];
      xj = vert_x[j];
      yj = vert_y[j];
      if ((yi > py) != (yj > py)) begin
        dy = yj - yi;
        lhs = (px - xi) * dy;
        rhs = (xj - xi) * (py - yi);
        if ((dy > 0) ? (lhs < rhs) : (rhs < lhs)) odd = !odd;
      end
    end
    return odd;
  endfunction

  function void note_item(logic mode, logic [$clog2(NV)-1:0] idx,
                          logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    if (mode == pip_pkg::MODE_WRITE) begin
      vert_x[idx] = x;
      vert_y[idx] = y;
    end else begin
      inside_due_q.insert(inside_due_q.size(), crossing_parity(x, y));
    end
  endfunction

  task check_inside(logic got);
    bit want;
    if (inside_due_q.size() == 0) begin
      report($sformatf("result %b arrived with no query waiting", got));
    end else begin
      want = inside_due_q.pop_front();
      if (got !== want) report($sformatf("inside_res got %b, expected %b", got, want));
      if (want) inside_seen++;
      else outside_seen++;
    end
  endtask

  function int pending();
    return inside_due_q.size();
  endfunction

  task flag_leftovers();
    if (inside_due_q.size() != 0)
      report($sformatf("%0d query results never arrived", inside_due_q.size()));
  endtask
endclass

module tb_top;
  localparam int NV = pip_pkg::MAX_VERTICES_DEF;
  localparam int CW = pip_pkg::COORD_BITS_DEF;
  localparam int IDX_BITS = $clog2(NV);
  localparam int CNT_BITS = $clog2(NV + 1);
  localparam int COORD_MAX = 2 ** (CW - 1) - 1;
  localparam int COORD_MIN = -(2 ** (CW - 1));
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 24;
  localparam int TAIL_CYCLES = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 1300;

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  logic in_mode;
  logic [IDX_BITS-1:0] in_vertex_index;
  logic signed [CW-1:0] in_coord_x;
  logic signed [CW-1:0] in_coord_y;
  logic empty;
  logic pop;
  logic out_inside_res;
  logic cfg_we;
  logic [CNT_BITS-1:0] cfg_vertex_count;

  int tx_idle_pct = 31;
  int rx_idle_pct = 71;
  int hold_req = 0;
  int items_sent = 0;
  int queries_sent = 0;
  int count_settings = 0;
  int live_count = 0;
  int special_counts [6] = '{0, 1, 2, 64, 65, 127};
  bit written [NV];
  logic signed [CW-1:0] last_x [NV];
  logic signed [CW-1:0] last_y [NV];

  inside_scoreboard sb = new();

  point_in_polygon_test_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_mode          (in_mode),
    .in_vertex_index  (in_vertex_index),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .empty            (empty),
    .pop              (pop),
    .out_inside_res   (out_inside_res),
    .cfg_we           (cfg_we),
    .cfg_vertex_count (cfg_vertex_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_count(cfg_vertex_count);
      if (push && !full) sb.note_item(in_mode, in_vertex_index, in_coord_x, in_coord_y);
      if (pop && !empty) sb.check_inside(out_inside_res);
    end
  end

  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (push && !full) || (pop && !empty)) idle_run = 0;
      else idle_run++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : result_side
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic signed [CW-1:0] near_coord(int center, int span);
    int v;
    v = center + int'($urandom_range(2 * span)) - span;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[CW-1:0];
  endfunction

  task automatic send_item(input logic mode, input logic [IDX_BITS-1:0] idx,
                           input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
    if (items_sent < ITEM_TARGET / 3) begin
      tx_idle_pct = 31;
      rx_idle_pct = 71;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      tx_idle_pct = 71;
      rx_idle_pct = 31;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_mode <= mode;
    in_vertex_index <= idx;
    in_coord_x <= x;
    in_coord_y <= y;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    if (mode == pip_pkg::MODE_QUERY) begin
      queries_sent++;
    end else begin
      written[idx] = 1'b1;
      last_x[idx] = x;
      last_y[idx] = y;
    end
  endtask

  // never let a query walk over a slot that holds no vertex yet
  task automatic send_query(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
    for (int k = 0; k < live_count; k++)
      if (!written[k])
        send_item(pip_pkg::MODE_WRITE, IDX_BITS'(k), CW'($urandom), CW'($urandom));
    send_item(pip_pkg::MODE_QUERY, IDX_BITS'($urandom_range(NV - 1)), x, y);
  endtask

  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int value);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_vertex_count <= CNT_BITS'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    live_count = (value > NV) ? NV : value;
    count_settings++;
  endtask

  task automatic run_polygon_phase(input int count_value, input int n_queries,
                                   input bit squeeze);
    int cx, cy, span, pick, k, k2;
    set_vertex_count(count_value);
    case ($urandom_range(3))
      0: span = 6;
      1: span = 300;
      2: span = 4000;
      default: span = COORD_MAX;
    endcase
    if (span == COORD_MAX) begin
      cx = 0;
      cy = 0;
    end else begin
      cx = int'($urandom_range(65535)) + COORD_MIN;
      cy = int'($urandom_range(65535)) + COORD_MIN;
    end
    for (k = 0; k < live_count; k++)
      send_item(pip_pkg::MODE_WRITE, IDX_BITS'(k), near_coord(cx, span),
                near_coord(cy, span));
    if (squeeze) hold_req = HOLD_CYCLES;
    for (int q = 0; q < n_queries; q++) begin
      pick = $urandom_range(99);
      k = (live_count > 0) ? $urandom_range(live_count - 1) : 0;
      k2 = (live_count > 0) ? $urandom_range(live_count - 1) : 0;
      if (pick < 65) begin
        send_query(near_coord(cx, span + span / 4), near_coord(cy, span + span / 4));
      end else if (pick < 78 && live_count > 0) begin
        // exact vertex coordinates hit the tie cases of the straddle and left tests
        send_query(last_x[k], last_y[k2]);
      end else if (pick < 84 && live_count > 0) begin
        send_query(near_coord(cx, span), last_y[k]);
      end else if (pick < 90) begin
        send_query(CW'($urandom), CW'($urandom));
      end else if (pick < 96) begin
        send_item(pip_pkg::MODE_WRITE, IDX_BITS'($urandom_range(NV - 1)),
                  near_coord(cx, span), near_coord(cy, span));
      end else begin
        send_item(pip_pkg::MODE_WRITE, IDX_BITS'($urandom_range(NV - 1)),
                  CW'($urandom), CW'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int p, count_value, n_queries;
    rst_n = 1'b0;
    push = 1'b0;
    in_mode = pip_pkg::MODE_WRITE;
    in_vertex_index = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    cfg_we = 1'b0;
    cfg_vertex_count = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // count of zero straight after reset
    send_query(CW'(0), CW'(0));
    send_query(CW'(COORD_MIN), CW'(COORD_MAX));

    // full-range square
    send_item(pip_pkg::MODE_WRITE, IDX_BITS'(0), CW'(COORD_MIN), CW'(COORD_MIN));
    send_item(pip_pkg::MODE_WRITE, IDX_BITS'(1), CW'(COORD_MAX), CW'(COORD_MIN));
    send_item(pip_pkg::MODE_WRITE, IDX_BITS'(2), CW'(COORD_MAX), CW'(COORD_MAX));
    send_item(pip_pkg::MODE_WRITE, IDX_BITS'(3), CW'(COORD_MIN), CW'(COORD_MAX));
    set_vertex_count(4);
    send_query(CW'(0), CW'(0));
    send_query(CW'(COORD_MIN), CW'(0));
    send_query(CW'(COORD_MAX), CW'(0));
    send_query(CW'(0), CW'(COORD_MIN));
    send_query(CW'(0), CW'(COORD_MAX));
    send_query(CW'(-1), CW'(-1));
    send_query(CW'(COORD_MIN), CW'(COORD_MIN));

    // single vertex and degenerate two-vertex polygon
    set_vertex_count(1);
    send_query(CW'(0), CW'(0));
    set_vertex_count(2);
    send_query(CW'(0), CW'(0));

    // triangle
    send_item(pip_pkg::MODE_WRITE, IDX_BITS'(2), CW'(0), CW'(COORD_MAX));
    set_vertex_count(3);
    send_query(CW'(0), CW'(0));
    send_query(CW'(16384), CW'(0));
    send_query(CW'(0), CW'(COORD_MIN + 1));
    send_item(pip_pkg::MODE_WRITE, IDX_BITS'(NV - 1), CW'(COORD_MAX), CW'(-1));

    p = 0;
    while (items_sent < ITEM_TARGET) begin
      if (p % 8 == 0) count_value = special_counts[(p / 8) % 6];
      else if ($urandom_range(9) == 0) count_value = $urandom_range(11, NV);
      else count_value = $urandom_range(3, 10);
      n_queries = (p % 6 == 2) ? 30 : $urandom_range(8, 24);
      run_polygon_phase(count_value, n_queries, p % 6 == 2);
      p++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.flag_leftovers();
    $display("summary: %0d items sent (%0d queries, %0d vertex writes) over %0d count settings",
             items_sent, queries_sent, items_sent - queries_sent, count_settings);
    $display("summary: %0d inside and %0d outside results checked, %0d mismatches",
             sb.inside_seen, sb.outside_seen, sb.fail_count);
    if (sb.fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/pip_pkg.sv
hw/rtl/pip_ram.sv
hw/rtl/pip_front.sv
hw/rtl/pip_rq.sv
hw/rtl/pip_back.sv
hw/rtl/point_in_polygon_test_core.sv
dv/tb_top.sv
